@@ hw/rtl/cldd_pkg.sv @@
// ----------------------------------------------------------------------------
// cldd_pkg
// Shared codes, widths and the command type for the batch dispatcher.
// ----------------------------------------------------------------------------
package cldd_pkg;

    // Field widths fixed by the interface
    localparam int OP_W    = 2;
    localparam int TAG_W   = 16;
    localparam int KIND_W  = 2;
    localparam int OUTS_W  = 7;
    localparam int BATCH_W = 7;

    // Most results one input transaction may cause
    localparam int MAX_RESULTS = 64;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SUBMIT     = 2'd0;
    localparam logic [OP_W-1:0] OP_COMPLETE   = 2'd1;
    localparam logic [OP_W-1:0] OP_ROUND_DONE = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 2'd2;

    // One unit of work for the back end: an optional leading result
    // (reject or error) followed by a batch of tags read from the wait queue.
    typedef struct packed {
        logic                has_lead;
        logic [KIND_W-1:0]   lead_kind;
        logic [TAG_W-1:0]    lead_tag;
        logic [OUTS_W-1:0]   outs;
        logic [BATCH_W-1:0]  batch;
    } t_cmd;

endpackage

@@ hw/rtl/credit_limited_batch_dispatcher_core.sv @@
// ----------------------------------------------------------------------------
// credit_limited_batch_dispatcher_core
// Credit-limited request queue that dispatches waiting tags in batches.
// ----------------------------------------------------------------------------
// The front end takes one transaction per cycle while the two-entry command
// queue has room and no slot reservation stalls it, so submits, completions
// and round-done markers are absorbed at full clock rate. Results leave
// through a registered output. The back end takes each command from the
// queue, emits any reject or error result, then for each dispatched tag reads
// the wait-queue RAM and loads the tag into the output register, waiting on
// output stalls. The input is held off while every free wait-queue slot is
// still reserved by a batch that the back end has not yet read. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module credit_limited_batch_dispatcher_core #(
    parameter int OUTSTANDING_LIMIT = 64,
    parameter int WAIT_DEPTH        = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [cldd_pkg::OP_W-1:0]        i_op,
    input  logic [cldd_pkg::TAG_W-1:0]       i_request_tag,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [cldd_pkg::OUTS_W-1:0]      i_cfg_max_outstanding,
    // result channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [cldd_pkg::KIND_W-1:0]      o_kind,
    output logic [cldd_pkg::TAG_W-1:0]       o_tag_out,
    output logic                             o_last_of_batch,
    output logic [cldd_pkg::OUTS_W-1:0]      o_outstanding_now
);

    localparam int PTR_W = $clog2(WAIT_DEPTH);

    logic                        cmd_push;
    logic                        cmd_pop;
    logic                        q_full;
    logic                        q_empty;
    cldd_pkg::t_cmd              cmd_in;
    cldd_pkg::t_cmd              cmd_head;
    logic                        ram_we;
    logic [PTR_W-1:0]            ram_waddr;
    logic [cldd_pkg::TAG_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [PTR_W-1:0]            ram_raddr;
    logic [cldd_pkg::TAG_W-1:0]  ram_rdata;

    // Front end: accept and classify
    cldd_front #(
        .OUTSTANDING_LIMIT (OUTSTANDING_LIMIT),
        .WAIT_DEPTH        (WAIT_DEPTH)
    ) u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_op                  (i_op),
        .i_request_tag         (i_request_tag),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_max_outstanding (i_cfg_max_outstanding),
        .i_q_full              (q_full),
        .o_push                (cmd_push),
        .o_cmd                 (cmd_in),
        .o_ram_we              (ram_we),
        .o_ram_waddr           (ram_waddr),
        .o_ram_wdata           (ram_wdata),
        .i_rd_pulse            (ram_re)
    );

    // Command queue
    cldd_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (cmd_head)
    );

    // Wait queue storage
    cldd_ram #(
        .WIDTH (cldd_pkg::TAG_W),
        .DEPTH (WAIT_DEPTH)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Back end: execute commands
    cldd_back #(
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_empty),
        .i_cmd             (cmd_head),
        .o_pop             (cmd_pop),
        .o_ram_re          (ram_re),
        .o_ram_raddr       (ram_raddr),
        .i_ram_rdata       (ram_rdata),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_kind            (o_kind),
        .o_tag_out         (o_tag_out),
        .o_last_of_batch   (o_last_of_batch),
        .o_outstanding_now (o_outstanding_now)
    );

    // Error results never carry a tag
    a_error_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == cldd_pkg::KIND_ERROR)) |-> (o_tag_out == '0))
        else $error("error result with nonzero tag");

    // A dispatched tag is counted and stays within OUTSTANDING_LIMIT
    a_dispatch_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == cldd_pkg::KIND_DISPATCH)) |->
        ((o_outstanding_now != '0) &&
         (o_outstanding_now <= cldd_pkg::OUTS_W'(OUTSTANDING_LIMIT))))
        else $error("dispatch result with bad outstanding count");

    // Front end never pushes into a full command queue
    a_no_cmd_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !q_full)
        else $error("command queue overflow");

    // A submit never overwrites a slot the back end is reading
    a_no_slot_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("wait queue write hits a reserved slot");

endmodule

@@ hw/rtl/cldd_ram.sv @@
// ----------------------------------------------------------------------------
// cldd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cldd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/cldd_front.sv @@
// ----------------------------------------------------------------------------
// cldd_front
// Accepts transactions, updates credit and queue bookkeeping, sizes batches.
// ----------------------------------------------------------------------------
module cldd_front #(
    parameter int OUTSTANDING_LIMIT = 64,
    parameter int WAIT_DEPTH        = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [cldd_pkg::OP_W-1:0]        i_op,
    input  logic [cldd_pkg::TAG_W-1:0]       i_request_tag,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [cldd_pkg::OUTS_W-1:0]      i_cfg_max_outstanding,
    // command queue
    input  logic                             i_q_full,
    output logic                             o_push,
    output cldd_pkg::t_cmd                   o_cmd,
    // wait queue write side
    output logic                             o_ram_we,
    output logic [$clog2(WAIT_DEPTH)-1:0]    o_ram_waddr,
    output logic [cldd_pkg::TAG_W-1:0]       o_ram_wdata,
    // one pulse per entry read by the back end
    input  logic                             i_rd_pulse
);

    localparam int CNT_W = $clog2(WAIT_DEPTH + 1);
    localparam int PTR_W = $clog2(WAIT_DEPTH);
    localparam int CMP_W = CNT_W + cldd_pkg::OUTS_W;
    localparam int OW    = cldd_pkg::OUTS_W;
    localparam int BW    = cldd_pkg::BATCH_W;

    logic [OW-1:0]    r_limit, n_limit;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_unread, n_unread;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [OW-1:0]    r_outs, n_outs;
    logic             r_active, n_active;

    logic                         accept;
    logic                         full;
    logic [CNT_W:0]               occupied;
    logic                         has_lead;
    logic [cldd_pkg::KIND_W-1:0]  lead_kind;
    logic [cldd_pkg::TAG_W-1:0]   lead_tag;
    logic [CNT_W-1:0]             cnt1;
    logic [OW-1:0]                outs1;
    logic                         act1;
    logic                         wr;
    logic [OW-1:0]                lim;
    logic                         go;
    logic [OW-1:0]                budget;
    logic [OW-1:0]                room;
    logic [BW-1:0]                b1;
    logic [BW-1:0]                batch;

    // Slots handed to the back end stay reserved until it has read them
    assign occupied = {1'b0, r_count} + {1'b0, r_unread};
    assign full     = (r_count == CNT_W'(WAIT_DEPTH));
    assign o_ready  = !i_q_full &&
                      !((r_unread != '0) && (occupied >= (CNT_W+1)'(WAIT_DEPTH)));
    assign accept   = i_valid && o_ready;

    // Per-operation effect
    always_comb begin
        has_lead  = 1'b0;
        lead_kind = cldd_pkg::KIND_DISPATCH;
        lead_tag  = '0;
        cnt1      = r_count;
        outs1     = r_outs;
        act1      = r_active;
        wr        = 1'b0;
        case (i_op)
            cldd_pkg::OP_SUBMIT: begin
                if (full) begin
                    has_lead  = 1'b1;
                    lead_kind = cldd_pkg::KIND_REJECT;
                    lead_tag  = i_request_tag;
                end else begin
                    cnt1 = r_count + CNT_W'(1);
                    wr   = 1'b1;
                end
            end
            cldd_pkg::OP_COMPLETE: begin
                if (r_outs == '0) begin
                    has_lead  = 1'b1;
                    lead_kind = cldd_pkg::KIND_ERROR;
                end else begin
                    outs1 = r_outs - OW'(1);
                end
            end
            cldd_pkg::OP_ROUND_DONE: begin
                if (!r_active) begin
                    has_lead  = 1'b1;
                    lead_kind = cldd_pkg::KIND_ERROR;
                end else begin
                    act1 = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Effective limit, clamped to 1..OUTSTANDING_LIMIT
    always_comb begin
        lim = r_limit;
        if (r_limit == '0) begin
            lim = OW'(1);
        end else if (r_limit > OW'(OUTSTANDING_LIMIT)) begin
            lim = OW'(OUTSTANDING_LIMIT);
        end
    end

    // Batch size: min of credit, result slots left and waiting tags
    assign go     = (outs1 < lim) && (cnt1 != '0) && !act1;
    assign budget = lim - outs1;
    assign room   = has_lead ? OW'(cldd_pkg::MAX_RESULTS - 1) : OW'(cldd_pkg::MAX_RESULTS);
    assign b1     = (budget < room) ? BW'(budget) : BW'(room);

    always_comb begin
        batch = '0;
        if (go) begin
            batch = (CMP_W'(cnt1) < CMP_W'(b1)) ? BW'(cnt1) : b1;
        end
    end

    // Next state
    always_comb begin
        n_limit  = r_limit;
        n_count  = r_count;
        n_tail   = r_tail;
        n_outs   = r_outs;
        n_active = r_active;
        n_unread = r_unread - CNT_W'(i_rd_pulse);
        if (i_cfg_we) begin
            n_limit = i_cfg_max_outstanding;
        end
        if (accept) begin
            n_count  = cnt1 - CNT_W'(batch);
            n_outs   = outs1 + OW'(batch);
            n_active = act1 | go;
            n_unread = r_unread + CNT_W'(batch) - CNT_W'(i_rd_pulse);
            if (wr) begin
                n_tail = (r_tail == PTR_W'(WAIT_DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= OW'(OUTSTANDING_LIMIT);
            r_count  <= '0;
            r_unread <= '0;
            r_tail   <= '0;
            r_outs   <= '0;
            r_active <= 1'b0;
        end else begin
            r_limit  <= n_limit;
            r_count  <= n_count;
            r_unread <= n_unread;
            r_tail   <= n_tail;
            r_outs   <= n_outs;
            r_active <= n_active;
        end
    end

    // Command toward the back end
    assign o_push          = accept && (has_lead || (batch != '0));
    assign o_cmd.has_lead  = has_lead;
    assign o_cmd.lead_kind = lead_kind;
    assign o_cmd.lead_tag  = lead_tag;
    assign o_cmd.outs      = outs1;
    assign o_cmd.batch     = batch;

    // Wait queue write
    assign o_ram_we    = accept && wr;
    assign o_ram_waddr = r_tail;
    assign o_ram_wdata = i_request_tag;

endmodule

@@ hw/rtl/cldd_cmd_q.sv @@
// ----------------------------------------------------------------------------
// cldd_cmd_q
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cldd_cmd_q (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cldd_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output cldd_pkg::t_cmd  o_head
);

    localparam int D     = cldd_pkg::CMDQ_DEPTH;
    localparam int PTR_W = $clog2(D);
    localparam int CNT_W = $clog2(D + 1);

    cldd_pkg::t_cmd   r_mem [D];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(D));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    // Pointer and count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(D - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_W'(D - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        n_cnt = r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

@@ hw/rtl/cldd_back.sv @@
// ----------------------------------------------------------------------------
// cldd_back
// Executes commands: emits the leading result if any, then reads and emits each tag.
// ----------------------------------------------------------------------------
module cldd_back #(
    parameter int WAIT_DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command queue
    input  logic                             i_q_empty,
    input  cldd_pkg::t_cmd                   i_cmd,
    output logic                             o_pop,
    // wait queue read side
    output logic                             o_ram_re,
    output logic [$clog2(WAIT_DEPTH)-1:0]    o_ram_raddr,
    input  logic [cldd_pkg::TAG_W-1:0]       i_ram_rdata,
    // result channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [cldd_pkg::KIND_W-1:0]      o_kind,
    output logic [cldd_pkg::TAG_W-1:0]       o_tag_out,
    output logic                             o_last_of_batch,
    output logic [cldd_pkg::OUTS_W-1:0]      o_outstanding_now
);

    localparam int PTR_W = $clog2(WAIT_DEPTH);
    localparam int OW    = cldd_pkg::OUTS_W;
    localparam int BW    = cldd_pkg::BATCH_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LEAD = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_TAG  = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [BW-1:0]                r_rem, n_rem;
    logic [OW-1:0]                r_outs, n_outs;
    logic [cldd_pkg::KIND_W-1:0]  r_lead_kind, n_lead_kind;
    logic [cldd_pkg::TAG_W-1:0]   r_lead_tag, n_lead_tag;
    logic [PTR_W-1:0]             r_rd_ptr, n_rd_ptr;

    logic                         r_out_valid;
    logic [cldd_pkg::KIND_W-1:0]  r_out_kind, n_out_kind;
    logic [cldd_pkg::TAG_W-1:0]   r_out_tag, n_out_tag;
    logic                         r_out_last, n_out_last;
    logic [OW-1:0]                r_out_outs, n_out_outs;

    logic out_free;
    logic out_load;

    // Output register is free when empty or being taken this cycle
    assign out_free = !r_out_valid || i_ready;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_outs      = r_outs;
        n_lead_kind = r_lead_kind;
        n_lead_tag  = r_lead_tag;
        n_rd_ptr    = r_rd_ptr;
        n_out_kind  = r_out_kind;
        n_out_tag   = r_out_tag;
        n_out_last  = r_out_last;
        n_out_outs  = r_out_outs;
        o_pop       = 1'b0;
        o_ram_re    = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop       = 1'b1;
                    n_lead_kind = i_cmd.lead_kind;
                    n_lead_tag  = i_cmd.lead_tag;
                    n_rem       = i_cmd.batch;
                    n_outs      = i_cmd.outs;
                    n_state     = i_cmd.has_lead ? S_LEAD : S_RD;
                end
            end
            S_LEAD: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out_kind = r_lead_kind;
                    n_out_tag  = r_lead_tag;
                    n_out_last = (r_rem == '0);
                    n_out_outs = r_outs;
                    n_state    = (r_rem == '0) ? S_IDLE : S_RD;
                end
            end
            S_RD: begin
                o_ram_re = 1'b1;
                n_rd_ptr = (r_rd_ptr == PTR_W'(WAIT_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
                n_state  = S_TAG;
            end
            S_TAG: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out_kind = cldd_pkg::KIND_DISPATCH;
                    n_out_tag  = i_ram_rdata;
                    n_out_last = (r_rem == BW'(1));
                    n_out_outs = r_outs + OW'(1);
                    n_outs     = r_outs + OW'(1);
                    n_rem      = r_rem - BW'(1);
                    n_state    = (r_rem == BW'(1)) ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ptr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_ptr <= n_rd_ptr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and output payload
    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_outs      <= n_outs;
        r_lead_kind <= n_lead_kind;
        r_lead_tag  <= n_lead_tag;
        r_out_kind  <= n_out_kind;
        r_out_tag   <= n_out_tag;
        r_out_last  <= n_out_last;
        r_out_outs  <= n_out_outs;
    end

    assign o_ram_raddr       = r_rd_ptr;
    assign o_valid           = r_out_valid;
    assign o_kind            = r_out_kind;
    assign o_tag_out         = r_out_tag;
    assign o_last_of_batch   = r_out_last;
    assign o_outstanding_now = r_out_outs;

endmodule

@@ verif/dispatch_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dispatch_checker
// Watches the request, configuration and result ports of the batch dispatcher.
// It tracks the wait queue, the credit count and the round flag, builds the
// expected results of every accepted request, and compares each result
// transaction field by field in order.
// ----------------------------------------------------------------------------
module dispatch_checker #(
    parameter int OUTSTANDING_LIMIT = 64,
    parameter int WAIT_DEPTH        = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request side
    input  logic                         i_req_valid,
    input  logic                         i_req_ready,
    input  logic [cldd_pkg::OP_W-1:0]    i_op,
    input  logic [cldd_pkg::TAG_W-1:0]   i_request_tag,
    // limit register writes
    input  logic                         i_cfg_we,
    input  logic [cldd_pkg::OUTS_W-1:0]  i_cfg_max_outstanding,
    // result side
    input  logic                         i_rsp_valid,
    input  logic                         i_rsp_ready,
    input  logic [cldd_pkg::KIND_W-1:0]  i_kind,
    input  logic [cldd_pkg::TAG_W-1:0]   i_tag_out,
    input  logic                         i_last_of_batch,
    input  logic [cldd_pkg::OUTS_W-1:0]  i_outstanding_now,
    // status for the top
    output int                           o_fail_count,
    output int                           o_pending
);

    localparam int MAX_PRINTS = 100;

    typedef struct packed {
        logic [cldd_pkg::KIND_W-1:0] kind;
        logic [cldd_pkg::TAG_W-1:0]  tag;
        logic                        last;
        logic [cldd_pkg::OUTS_W-1:0] outs;
    } t_dispatch_rsp;

    // expected results, oldest first
    t_dispatch_rsp                dispatch_exp_q[$];

    // mirror of the block state
    logic [cldd_pkg::TAG_W-1:0]   wait_tags [WAIT_DEPTH];
    int unsigned                  wait_head;
    int unsigned                  wait_tail;
    int unsigned                  wait_count;
    logic [cldd_pkg::OUTS_W-1:0]  credits_used;
    logic                         round_busy;
    logic [cldd_pkg::OUTS_W-1:0]  limit_reg;

    int                           mismatches = 0;
    int                           item_results;

    // One line per mismatch; printing stops after MAX_PRINTS, counting does not
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTS)
            $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic add_result(input logic [cldd_pkg::KIND_W-1:0] kind,
                              input logic [cldd_pkg::TAG_W-1:0] tag);
        t_dispatch_rsp r;
        r.kind = kind;
        r.tag  = tag;
        r.last = 1'b0;
        r.outs = credits_used;
        dispatch_exp_q.insert(dispatch_exp_q.size(), r);
        item_results++;
    endtask

    // Work out the results of one request transaction
    task automatic predict_item(input logic [cldd_pkg::OP_W-1:0] op,
                                input logic [cldd_pkg::TAG_W-1:0] tag);
        int unsigned   lim;
        int unsigned   budget;
        item_results = 0;
        case (op)
            cldd_pkg::OP_SUBMIT: begin
                if (wait_count >= WAIT_DEPTH) begin
                    add_result(cldd_pkg::KIND_REJECT, tag);
                end else begin
                    wait_tags[wait_tail] = tag;
                    wait_tail = (wait_tail + 1) % WAIT_DEPTH;
                    wait_count++;
                end
            end
            cldd_pkg::OP_COMPLETE: begin
                if (credits_used == 0)
                    add_result(cldd_pkg::KIND_ERROR, {cldd_pkg::TAG_W{1'b0}});
                else
                    credits_used--;
            end
            cldd_pkg::OP_ROUND_DONE: begin
                if (!round_busy)
                    add_result(cldd_pkg::KIND_ERROR, {cldd_pkg::TAG_W{1'b0}});
                else
                    round_busy = 1'b0;
            end
            default: ;  // unused code: nothing of its own
        endcase

        // dispatch check follows every transaction; limit clamped to 1..max
        if (limit_reg == 0)
            lim = 1;
        else if (limit_reg > OUTSTANDING_LIMIT)
            lim = OUTSTANDING_LIMIT;
        else
            lim = 32'(limit_reg);
        if (credits_used < lim && wait_count > 0 && !round_busy) begin
            budget = lim - 32'(credits_used);
            if (budget > cldd_pkg::MAX_RESULTS - item_results)
                budget = cldd_pkg::MAX_RESULTS - item_results;
            while (wait_count > 0 && budget > 0) begin
                credits_used++;
                add_result(cldd_pkg::KIND_DISPATCH, wait_tags[wait_head]);
                wait_head = (wait_head + 1) % WAIT_DEPTH;
                wait_count--;
                budget--;
            end
            round_busy = 1'b1;
        end

        // flag the final result of this transaction
        if (item_results > 0)
            dispatch_exp_q[dispatch_exp_q.size() - 1].last = 1'b1;
    endtask

    task automatic check_result();
        t_dispatch_rsp want;
        if (dispatch_exp_q.size() == 0) begin
            report_mismatch("unexpected result, tag", 32'(i_tag_out), 32'd0);
        end else begin
            want = dispatch_exp_q.pop_front();
            if (i_kind !== want.kind)
                report_mismatch("kind", 32'(i_kind), 32'(want.kind));
            if (i_tag_out !== want.tag)
                report_mismatch("tag_out", 32'(i_tag_out), 32'(want.tag));
            if (i_last_of_batch !== want.last)
                report_mismatch("last_of_batch", 32'(i_last_of_batch), 32'(want.last));
            if (i_outstanding_now !== want.outs)
                report_mismatch("outstanding_now", 32'(i_outstanding_now),
                                32'(want.outs));
        end
    endtask

    // Sample all ports at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dispatch_exp_q.delete();
            wait_head    = 0;
            wait_tail    = 0;
            wait_count   = 0;
            credits_used = '0;
            round_busy   = 1'b0;
            limit_reg    = cldd_pkg::OUTS_W'(OUTSTANDING_LIMIT);
        end else begin
            if (i_rsp_valid && i_rsp_ready)
                check_result();
            if (i_cfg_we)
                limit_reg = i_cfg_max_outstanding;
            if (i_req_valid && i_req_ready)
                predict_item(i_op, i_request_tag);
        end
        o_pending    <= dispatch_exp_q.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the credit-limited batch dispatcher. A short directed run hits
// the error and ignore cases, a wait-queue fill forces rejects and the capped
// batch, then random phases vary the credit limit and the op mix. Both
// channels idle in random bursts; one phase holds the result side off for a
// long stretch. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_PERIOD        = 8;
    localparam int RESET_CYCLES      = 10;
    localparam int OUTSTANDING_LIMIT = 64;
    localparam int WAIT_DEPTH        = 64;
    localparam int SETTLE_CYCLES     = 32;
    localparam int DRAIN_CYCLES      = 64;
    localparam int LONG_STALL        = 400;
    localparam int RANDOM_ITEMS      = 104;
    localparam int PHASE_ITEMS       = 26;
    localparam int PRESSURE_PHASE    = 3;
    localparam int RUN_LIMIT_NS      = 8_000_000;

    // op code the block ignores
    localparam logic [cldd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic [cldd_pkg::OP_W-1:0]     i_op;
    logic [cldd_pkg::TAG_W-1:0]    i_request_tag;
    logic                          i_cfg_we;
    logic [cldd_pkg::OUTS_W-1:0]   i_cfg_max_outstanding;
    logic                          o_valid;
    logic                          i_ready;
    logic [cldd_pkg::KIND_W-1:0]   o_kind;
    logic [cldd_pkg::TAG_W-1:0]    o_tag_out;
    logic                          o_last_of_batch;
    logic [cldd_pkg::OUTS_W-1:0]   o_outstanding_now;

    int                            fail_count;
    int                            pending;
    int                            phase_no = 0;
    logic                          quiet = 1'b0;
    logic                          pressure_armed = 1'b0;

    credit_limited_batch_dispatcher_core #(
        .OUTSTANDING_LIMIT (OUTSTANDING_LIMIT),
        .WAIT_DEPTH        (WAIT_DEPTH)
    ) i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_op                  (i_op),
        .i_request_tag         (i_request_tag),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_max_outstanding (i_cfg_max_outstanding),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_kind                (o_kind),
        .o_tag_out             (o_tag_out),
        .o_last_of_batch       (o_last_of_batch),
        .o_outstanding_now     (o_outstanding_now)
    );

    dispatch_checker #(
        .OUTSTANDING_LIMIT (OUTSTANDING_LIMIT),
        .WAIT_DEPTH        (WAIT_DEPTH)
    ) dispatch_check (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_req_valid           (i_valid),
        .i_req_ready           (o_ready),
        .i_op                  (i_op),
        .i_request_tag         (i_request_tag),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_max_outstanding (i_cfg_max_outstanding),
        .i_rsp_valid           (o_valid),
        .i_rsp_ready           (i_ready),
        .i_kind                (o_kind),
        .i_tag_out             (o_tag_out),
        .i_last_of_batch       (o_last_of_batch),
        .i_outstanding_now     (o_outstanding_now),
        .o_fail_count          (fail_count),
        .o_pending             (pending)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    // Result side: random back-pressure, one long hold during the pressure phase
    initial begin : result_sink
        bit pressure_done;
        pressure_done = 1'b0;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (pressure_armed && !pressure_done) begin
                pressure_done = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one request and hold it until the block takes it
    task automatic send_item(input logic [cldd_pkg::OP_W-1:0] op,
                             input logic [cldd_pkg::TAG_W-1:0] tag);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_request_tag <= tag;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Stop offering, wait for every expected result and let the pipe empty
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [cldd_pkg::OUTS_W-1:0] value);
        settle();
        i_cfg_we              <= 1'b1;
        i_cfg_max_outstanding <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int                            sent;
        int                            pick;
        int                            submit_pct;
        int                            complete_pct;
        int                            done_pct;
        logic [cldd_pkg::OP_W-1:0]     op;
        logic [cldd_pkg::OUTS_W-1:0]   lim;

        i_rst_n               <= 1'b0;
        i_valid               <= 1'b0;
        i_op                  <= cldd_pkg::OP_SUBMIT;
        i_request_tag         <= '0;
        i_cfg_we              <= 1'b0;
        i_cfg_max_outstanding <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // errors on an idle block, ignored code, first batch at the reset limit
        send_item(cldd_pkg::OP_COMPLETE, 16'h1234);
        send_item(cldd_pkg::OP_ROUND_DONE, 16'hFFFF);
        send_item(OP_UNUSED, 16'h0000);
        send_item(cldd_pkg::OP_SUBMIT, 16'h0000);
        send_item(cldd_pkg::OP_SUBMIT, 16'hFFFF);
        send_item(cldd_pkg::OP_SUBMIT, 16'hA5A5);
        send_item(cldd_pkg::OP_SUBMIT, 16'h5A5A);
        send_item(cldd_pkg::OP_COMPLETE, 16'h0000);
        send_item(cldd_pkg::OP_COMPLETE, 16'h0000);
        send_item(OP_UNUSED, 16'hFFFF);
        send_item(cldd_pkg::OP_ROUND_DONE, 16'h0000);
        send_item(cldd_pkg::OP_ROUND_DONE, 16'h0000);
        send_item(cldd_pkg::OP_ROUND_DONE, 16'h0000);
        repeat (3) send_item(cldd_pkg::OP_COMPLETE, 16'h0000);

        // limit of zero acts as one credit
        write_limit(7'd0);
        send_item(cldd_pkg::OP_SUBMIT, 16'h0001);
        send_item(cldd_pkg::OP_SUBMIT, 16'h8000);
        send_item(cldd_pkg::OP_ROUND_DONE, 16'h0000);
        send_item(cldd_pkg::OP_COMPLETE, 16'h0000);
        send_item(cldd_pkg::OP_ROUND_DONE, 16'h0000);
        send_item(cldd_pkg::OP_COMPLETE, 16'h0000);

        // fill the wait queue behind one credit, then overflow it
        write_limit(7'd1);
        send_item(cldd_pkg::OP_SUBMIT, cldd_pkg::TAG_W'($urandom_range(0, 65535)));
        send_item(cldd_pkg::OP_ROUND_DONE, 16'h0000);
        repeat (WAIT_DEPTH)
            send_item(cldd_pkg::OP_SUBMIT, cldd_pkg::TAG_W'($urandom_range(0, 65535)));
        send_item(cldd_pkg::OP_SUBMIT, cldd_pkg::TAG_W'($urandom_range(0, 65535)));

        // raising the limit: reject plus the largest batch the result slots allow
        write_limit(7'd64);
        send_item(cldd_pkg::OP_SUBMIT, cldd_pkg::TAG_W'($urandom_range(0, 65535)));

        // limit dropped far below the outstanding count
        write_limit(7'd2);
        send_item(cldd_pkg::OP_ROUND_DONE, 16'h0000);
        repeat (OUTSTANDING_LIMIT)
            send_item(cldd_pkg::OP_COMPLETE, cldd_pkg::TAG_W'($urandom_range(0, 65535)));
        send_item(cldd_pkg::OP_ROUND_DONE, 16'h0000);

        // random phases, each with its own limit and op mix
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       lim = 7'd0;
                1:       lim = 7'd1;
                2:       lim = 7'd127;
                3:       lim = 7'd64;
                4:       lim = cldd_pkg::OUTS_W'($urandom_range(2, 8));
                default: lim = cldd_pkg::OUTS_W'($urandom_range(0, 127));
            endcase
            phase_no++;
            if (phase_no == PRESSURE_PHASE)
                lim = cldd_pkg::OUTS_W'(OUTSTANDING_LIMIT);
            write_limit(lim);
            // long result-side hold starts only once items are being offered
            if (phase_no == PRESSURE_PHASE)
                pressure_armed = 1'b1;
            quiet = (sent + PHASE_ITEMS >= RANDOM_ITEMS) || (phase_no == PRESSURE_PHASE)
                    || ($urandom_range(0, 3) == 0);
            if (phase_no == PRESSURE_PHASE) begin
                submit_pct   = 40;
                complete_pct = 30;
            end else begin
                submit_pct   = $urandom_range(30, 70);
                complete_pct = (100 - submit_pct) * 2 / 3;
            end
            done_pct = 97 - submit_pct - complete_pct;

            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < submit_pct)
                    op = cldd_pkg::OP_SUBMIT;
                else if (pick < submit_pct + complete_pct)
                    op = cldd_pkg::OP_COMPLETE;
                else if (pick < submit_pct + complete_pct + done_pct)
                    op = cldd_pkg::OP_ROUND_DONE;
                else
                    op = OP_UNUSED;
                send_item(op, cldd_pkg::TAG_W'($urandom_range(0, 65535)));
                sent++;
            end
        end

        // drain and give the verdict
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
